// ===== rtl/core/dcr_pkg.sv =====
// dcr_pkg: shared widths, register codes and pipeline types of the registration core
`default_nettype none
package dcr_pkg;

    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int DEPTH_W    = 16;
    localparam int NUM_W      = 58;
    localparam int DEN_W      = 40;
    localparam int QUO_W      = 43;
    localparam int MAG_W      = 43;
    localparam int PROD_W     = 63;
    localparam int ACC_W      = 64;
    localparam int POS_W      = 39;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam logic [MAG_W-1:0] RATIO_LIM = MAG_W'(1) << 42;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DFX = 4'd0,
        REG_DFY = 4'd1,
        REG_DCX = 4'd2,
        REG_DCY = 4'd3,
        REG_CFX = 4'd4,
        REG_CFY = 4'd5,
        REG_CCX = 4'd6,
        REG_CCY = 4'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_DFX = 20'd100074;
    localparam logic [CFG_W-1:0] RST_DFY = 20'd100074;
    localparam logic [CFG_W-1:0] RST_DCX = 20'd82896;
    localparam logic [CFG_W-1:0] RST_DCY = 20'd60970;
    localparam logic [CFG_W-1:0] RST_CFX = 20'd155123;
    localparam logic [CFG_W-1:0] RST_CFY = 20'd155102;
    localparam logic [CFG_W-1:0] RST_CCX = 20'd81329;
    localparam logic [CFG_W-1:0] RST_CCY = 20'd64849;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
    } t_div_in;

    typedef struct packed {
        logic               neg;
        logic [MAG_W-1:0]   mag;
    } t_ratio;

    typedef struct packed {
        logic               ok;
        logic [DEPTH_W-1:0] depth;
    } t_side;

endpackage
`default_nettype wire

// ===== rtl/core/dcr_pix_if.sv =====
// dcr_pix_if: depth pixel channel
`default_nettype none
interface dcr_pix_if;
    logic        valid;
    logic        ready;
    logic [9:0]  pixel_col;
    logic [8:0]  pixel_row;
    logic [15:0] depth_mm;

    modport source (output valid, output pixel_col, output pixel_row, output depth_mm,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input depth_mm,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dcr_res_if.sv =====
// dcr_res_if: registered color pixel result channel
`default_nettype none
interface dcr_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  target_col;
    logic [8:0]  target_row;
    logic [15:0] depth_out;
    logic        write_enable;

    modport source (output valid, output target_col, output target_row, output depth_out,
                    output write_enable, input ready);
    modport sink   (input valid, input target_col, input target_row, input depth_out,
                    input write_enable, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dcr_front.sv =====
// dcr_front: back-projection numerators and denominators, four stages
`default_nettype none
module dcr_front
    import dcr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [COL_W-1:0]    i_col,
    input  wire logic [ROW_W-1:0]    i_row,
    input  wire logic [DEPTH_W-1:0]  i_depth,
    input  wire logic [CFG_W-1:0]    i_dfx,
    input  wire logic [CFG_W-1:0]    i_dfy,
    input  wire logic [CFG_W-1:0]    i_dcx,
    input  wire logic [CFG_W-1:0]    i_dcy,
    output logic                     o_valid,
    output t_div_in [1:0]            o_div,
    output t_side                    o_side
);

    logic               r1_v, r2_v, r3_v, r4_v;
    t_side              r1_side, r2_side, r3_side, r4_side;
    logic signed [20:0] r1_dx, r1_dy;
    logic [20:0]        r1_zt;
    logic signed [37:0] r2_pxd, r2_pyd;
    logic [DEN_W-1:0]   r2_denx, r2_deny, r3_denx, r3_deny;
    logic [37:0]        r3_magx, r3_magy;
    logic               r3_negx, r3_negy;
    t_div_in [1:0]      r4_div;

    logic signed [20:0] n_dx, n_dy;
    logic [20:0]        n_zt;
    logic signed [37:0] n_pxd, n_pyd;
    logic [23:0]        n_m15;
    logic [38:0]        n_sx, n_ax;
    logic [37:0]        n_ay;
    logic [NUM_W-1:0]   n_nx, n_ny;

    assign n_dx  = $signed({3'b0, i_col, 8'b0} - {1'b0, i_dcx});
    assign n_dy  = $signed({4'b0, i_row, 8'b0} - {1'b0, i_dcy});
    assign n_zt  = 21'(i_depth) * 21'd10 - 21'd27;
    assign n_pxd = r1_dx * $signed({1'b0, r1_side.depth});
    assign n_pyd = r1_dy * $signed({1'b0, r1_side.depth});
    assign n_m15 = {i_dfx, 4'b0} - {4'b0, i_dfx};
    assign n_sx  = {r2_pxd[37], r2_pxd} + {15'b0, n_m15};
    assign n_ax  = n_sx[38] ? (~n_sx + 39'd1) : n_sx;
    assign n_ay  = r2_pyd[37] ? (~r2_pyd + 38'd1) : r2_pyd;
    // times 10 * 2^16
    assign n_nx  = {1'b0, r3_magx, 19'b0} + {3'b0, r3_magx, 17'b0};
    assign n_ny  = {1'b0, r3_magy, 19'b0} + {3'b0, r3_magy, 17'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx         <= n_dx;
            r1_dy         <= n_dy;
            r1_zt         <= n_zt;
            r1_side.depth <= i_depth;
            r1_side.ok    <= (i_depth >= 16'd3) && (i_dfx != '0) && (i_dfy != '0);

            r2_side <= r1_side;
            r2_pxd  <= n_pxd;
            r2_pyd  <= n_pyd;
            r2_denx <= i_dfx * r1_zt[19:0];
            r2_deny <= i_dfy * r1_zt[19:0];

            r3_side <= r2_side;
            r3_denx <= r2_denx;
            r3_deny <= r2_deny;
            r3_magx <= n_ax[37:0];
            r3_negx <= n_sx[38];
            r3_magy <= n_ay;
            r3_negy <= r2_pyd[37];

            r4_side        <= r3_side;
            r4_div[0].num  <= n_nx;
            r4_div[0].den  <= r3_denx;
            r4_div[0].neg  <= r3_negx;
            r4_div[0].ovf  <= {25'b0, n_nx} >= {r3_denx, 43'b0};
            r4_div[1].num  <= n_ny;
            r4_div[1].den  <= r3_deny;
            r4_div[1].neg  <= r3_negy;
            r4_div[1].ovf  <= {25'b0, n_ny} >= {r3_deny, 43'b0};
        end
    end

    assign o_valid = r4_v;
    assign o_div   = r4_div;
    assign o_side  = r4_side;

endmodule
`default_nettype wire

// ===== rtl/core/dcr_div.sv =====
// dcr_div: two-lane restoring divider, one quotient bit per stage, floor and saturation
`default_nettype none
module dcr_div
    import dcr_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire t_div_in [1:0]  i_div,
    input  wire t_side          i_side,
    output logic                o_valid,
    output t_ratio [1:0]        o_ratio,
    output t_side               o_side
);

    logic [QUO_W-1:0] r_v;
    t_side            r_side [QUO_W];
    logic [DEN_W-1:0] r_rem  [2][QUO_W];
    logic [QUO_W-1:0] r_num  [2][QUO_W];
    logic [QUO_W-1:0] r_quo  [2][QUO_W];
    logic [DEN_W-1:0] r_den  [2][QUO_W];
    logic [1:0]       r_neg  [QUO_W];
    logic [1:0]       r_ovf  [QUO_W];
    logic             r_ov;
    t_ratio [1:0]     r_ratio;
    t_side            r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[QUO_W-2:0], i_valid};
            r_ov <= r_v[QUO_W-1];
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [1:0] neg_in, ovf_in;
        t_side      side_in;
        if (s == 0) begin : g_first
            assign neg_in  = {i_div[1].neg, i_div[0].neg};
            assign ovf_in  = {i_div[1].ovf, i_div[0].ovf};
            assign side_in = i_side;
        end else begin : g_next
            assign neg_in  = r_neg[s-1];
            assign ovf_in  = r_ovf[s-1];
            assign side_in = r_side[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[s]  <= neg_in;
                r_ovf[s]  <= ovf_in;
                r_side[s] <= side_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DEN_W-1:0] rem_in, den_in;
            logic [QUO_W-1:0] num_in, quo_in;
            logic [DEN_W:0]   t;
            logic             ge;
            logic [DEN_W:0]   diff;
            if (s == 0) begin : g_first
                assign rem_in = DEN_W'(i_div[l].num[NUM_W-1:QUO_W]);
                assign num_in = i_div[l].num[QUO_W-1:0];
                assign quo_in = '0;
                assign den_in = i_div[l].den;
            end else begin : g_next
                assign rem_in = r_rem[l][s-1];
                assign num_in = r_num[l][s-1];
                assign quo_in = r_quo[l][s-1];
                assign den_in = r_den[l][s-1];
            end
            assign t    = {rem_in, num_in[QUO_W-1]};
            assign ge   = t >= {1'b0, den_in};
            assign diff = t - {1'b0, den_in};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][s] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                    r_num[l][s] <= {num_in[QUO_W-2:0], 1'b0};
                    r_quo[l][s] <= {quo_in[QUO_W-2:0], ge};
                    r_den[l][s] <= den_in;
                end
            end
        end
    end

    // floor for negative ratios, then clamp to the ratio limit
    for (genvar l = 0; l < 2; l++) begin : g_post
        logic [MAG_W:0] mag;
        assign mag = {1'b0, r_quo[l][QUO_W-1]}
                   + (MAG_W+1)'(r_neg[QUO_W-1][l] && (r_rem[l][QUO_W-1] != '0));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ratio[l].neg <= r_neg[QUO_W-1][l];
                r_ratio[l].mag <= (r_ovf[QUO_W-1][l] || (mag > {1'b0, RATIO_LIM}))
                                ? RATIO_LIM : mag[MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oside <= r_side[QUO_W-1];
        end
    end

    assign o_valid = r_ov;
    assign o_ratio = r_ratio;
    assign o_side  = r_oside;

endmodule
`default_nettype wire

// ===== rtl/core/dcr_proj.sv =====
// dcr_proj: color camera projection, frame test and result register
`default_nettype none
module dcr_proj
    import dcr_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire t_ratio [1:0]        i_ratio,
    input  wire t_side               i_side,
    input  wire logic [CFG_W-1:0]    i_cfx,
    input  wire logic [CFG_W-1:0]    i_cfy,
    input  wire logic [CFG_W-1:0]    i_ccx,
    input  wire logic [CFG_W-1:0]    i_ccy,
    output logic                     o_valid,
    output logic [COL_W-1:0]         o_col,
    output logic [ROW_W-1:0]         o_row,
    output logic [DEPTH_W-1:0]       o_depth,
    output logic                     o_we
);

    logic             r1_v, r2_v, r3_v, r4_v;
    t_side            r1_side, r2_side, r3_side;
    logic [41:0]      r1_plo [2];
    logic [40:0]      r1_phi [2];
    logic [1:0]       r1_neg, r2_neg;
    logic [PROD_W-1:0] r2_prod [2];
    logic [ACC_W-1:0] r3_acc [2];
    logic [COL_W-1:0]  r4_col;
    logic [ROW_W-1:0]  r4_row;
    logic [DEPTH_W-1:0] r4_depth;
    logic              r4_we;

    logic [CFG_W-1:0]  cf [2];
    logic [CFG_W-1:0]  cc [2];
    logic [36:0]       base [2];
    logic [POS_W-1:0]  pu, pv;
    logic              n_we;

    assign cf[0] = i_cfx;
    assign cf[1] = i_cfy;
    assign cc[0] = i_ccx;
    assign cc[1] = i_ccy;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign base[l] = {1'b0, cc[l], 16'b0} + 37'h800000;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_plo[l]  <= i_ratio[l].mag[21:0] * cf[l];
                r1_phi[l]  <= i_ratio[l].mag[42:22] * cf[l];
                r2_prod[l] <= {21'b0, r1_plo[l]} + {r1_phi[l], 22'b0};
                r3_acc[l]  <= r2_neg[l] ? ({27'b0, base[l]} - {1'b0, r2_prod[l]})
                                        : ({27'b0, base[l]} + {1'b0, r2_prod[l]});
            end
        end
    end

    assign pu   = r3_acc[0][62:24];
    assign pv   = r3_acc[1][62:24];
    assign n_we = r3_side.ok && !r3_acc[0][ACC_W-1] && !r3_acc[1][ACC_W-1]
               && (pu != '0) && (pu < POS_W'(FRAME_WIDTH))
               && (pv != '0) && (pv < POS_W'(FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side  <= i_side;
            r1_neg   <= {i_ratio[1].neg, i_ratio[0].neg};
            r2_side  <= r1_side;
            r2_neg   <= r1_neg;
            r3_side  <= r2_side;
            r4_we    <= n_we;
            r4_col   <= n_we ? pu[COL_W-1:0] : '0;
            r4_row   <= n_we ? pv[ROW_W-1:0] : '0;
            r4_depth <= n_we ? r3_side.depth : '0;
        end
    end

    assign o_valid = r4_v;
    assign o_col   = r4_col;
    assign o_row   = r4_row;
    assign o_depth = r4_depth;
    assign o_we    = r4_we;

endmodule
`default_nettype wire

// ===== rtl/core/depth_to_color_pixel_registration_core.sv =====
// depth_to_color_pixel_registration_core: depth pixel to color pixel registration top level
//
//  channel   dir  payload                                         handshake
//  i_pix     in   pixel_col, pixel_row, depth_mm                  valid / ready
//  o_res     out  target_col, target_row, depth_out, write_enable valid / ready
//  cfg       in   i_cfg_idx, i_cfg_data                           i_cfg_we
//
// one word per cycle while the output is not stalled; 4 front stages, 43 divider stages
// (one quotient bit each) plus a clamp stage, 4 projection stages incl. the result register
// a stall freezes the whole pipeline; i_pix.ready is low only while a result waits
// synchronous active-low reset clears valid bits and restores register defaults
`default_nettype none
module depth_to_color_pixel_registration_core
    import dcr_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    dcr_pix_if.sink                   i_pix,
    dcr_res_if.source                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_dfx, r_dfy, r_dcx, r_dcy, r_cfx, r_cfy, r_ccx, r_ccy;
    logic             en;
    logic             f_valid, d_valid;
    t_div_in [1:0]    f_div;
    t_side            f_side, d_side;
    t_ratio [1:0]     d_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dfx <= RST_DFX;
            r_dfy <= RST_DFY;
            r_dcx <= RST_DCX;
            r_dcy <= RST_DCY;
            r_cfx <= RST_CFX;
            r_cfy <= RST_CFY;
            r_ccx <= RST_CCX;
            r_ccy <= RST_CCY;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DFX: r_dfx <= i_cfg_data;
                REG_DFY: r_dfy <= i_cfg_data;
                REG_DCX: r_dcx <= i_cfg_data;
                REG_DCY: r_dcy <= i_cfg_data;
                REG_CFX: r_cfx <= i_cfg_data;
                REG_CFY: r_cfy <= i_cfg_data;
                REG_CCX: r_ccx <= i_cfg_data;
                REG_CCY: r_ccy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en          = !o_res.valid || o_res.ready;
    assign i_pix.ready = en;

    dcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_col   (i_pix.pixel_col),
        .i_row   (i_pix.pixel_row),
        .i_depth (i_pix.depth_mm),
        .i_dfx   (r_dfx),
        .i_dfy   (r_dfy),
        .i_dcx   (r_dcx),
        .i_dcy   (r_dcy),
        .o_valid (f_valid),
        .o_div   (f_div),
        .o_side  (f_side)
    );

    dcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_div   (f_div),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_ratio (d_ratio),
        .o_side  (d_side)
    );

    dcr_proj #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_ratio (d_ratio),
        .i_side  (d_side),
        .i_cfx   (r_cfx),
        .i_cfy   (r_cfy),
        .i_ccx   (r_ccx),
        .i_ccy   (r_ccy),
        .o_valid (o_res.valid),
        .o_col   (o_res.target_col),
        .o_row   (o_res.target_row),
        .o_depth (o_res.depth_out),
        .o_we    (o_res.write_enable)
    );

endmodule
`default_nettype wire
